### hdl/snpu_pkg.sv
// ----------------------------------------------------------------------------
// snpu_pkg: shared types and constants for the spiking neuron population
// Fixed-point formats, register indexes, reset values and saturation helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package snpu_pkg;

  localparam int IDX_W      = 10;
  localparam int DATA_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int RATE_W     = 16;
  localparam int POT_W      = 24;
  localparam int STEP_W     = 20;
  localparam int LIN_W      = 36;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_RATE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_SENSITIVITY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESET_POTENTIAL      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY_JUMP        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PEAK_POTENTIAL       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_POTENTIAL    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_MS              = 3'd6;

  // Register values after reset.
  localparam logic [RATE_W-1:0] RST_RECOVERY_RATE        = 16'd1311;
  localparam logic [RATE_W-1:0] RST_RECOVERY_SENSITIVITY = 16'd13107;
  localparam logic [POT_W-1:0]  RST_RESET_POTENTIAL      = 24'hBF0000;
  localparam logic [POT_W-1:0]  RST_RECOVERY_JUMP        = 24'h080000;
  localparam logic [POT_W-1:0]  RST_PEAK_POTENTIAL       = 24'h1E0000;
  localparam logic [POT_W-1:0]  RST_INITIAL_POTENTIAL    = 24'hBF0000;
  localparam logic [STEP_W-1:0] RST_STEP_MS              = 20'h10000;

  // 0.04 in Q0.16 and 140.0 in Q15.16.
  localparam logic [11:0]             K_QUAD = 12'd2621;
  localparam logic signed [LIN_W-1:0] Q_140  = 36'sd9175040;

  localparam logic signed [63:0] FIX_MAX = 64'sd2147483647;
  localparam logic signed [63:0] FIX_MIN = -64'sd2147483648;

  typedef logic signed [DATA_W-1:0] fix_t;

  // Side information that travels with an item down the update pipeline.
  typedef struct packed {
    logic             action;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] slot;
    fix_t             cur;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             spiked;
    fix_t             v;
    fix_t             u;
  } result_t;

  function automatic fix_t sat32(input logic signed [63:0] x);
    if (x > FIX_MAX) begin
      return fix_t'(FIX_MAX);
    end else if (x < FIX_MIN) begin
      return fix_t'(FIX_MIN);
    end
    return fix_t'(x);
  endfunction

endpackage

### hdl/snpu_step_if.sv
// ----------------------------------------------------------------------------
// snpu_step_if: step item channel
// Carries the action, the neuron index and the input current of one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface snpu_step_if;
  import snpu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     action;
  logic [IDX_W-1:0]         neuron_index;
  logic signed [DATA_W-1:0] input_current;

  modport source (output valid, action, neuron_index, input_current, input ready);
  modport sink   (input valid, action, neuron_index, input_current, output ready);
endinterface

### hdl/snpu_result_if.sv
// ----------------------------------------------------------------------------
// snpu_result_if: result item channel
// Carries the updated state and the spike flag of one neuron.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface snpu_result_if;
  import snpu_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [IDX_W-1:0]         out_index;
  logic                     spiked;
  logic signed [DATA_W-1:0] new_potential;
  logic signed [DATA_W-1:0] new_recovery;

  modport source (output valid, out_index, spiked, new_potential, new_recovery,
                  input ready);
  modport sink   (input valid, out_index, spiked, new_potential, new_recovery,
                  output ready);
endinterface

### hdl/snpu_cfg_if.sv
// ----------------------------------------------------------------------------
// snpu_cfg_if: configuration write channel
// Carries a register index and the data to be written there.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface snpu_cfg_if;
  import snpu_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### hdl/spiking_neuron_population_update.sv
// ----------------------------------------------------------------------------
// spiking_neuron_population_update: neuron state update, one item per cycle when not stalled
// Throughput: one item per cycle; an item for a neuron still in the pipeline
// waits until that update is written back to the state memory, and items
// also wait while every result queue entry is reserved.
// Reset: control and registers to defaults; the state memory is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spiking_neuron_population_update #(
  parameter int NEURONS = 1024
) (
  input logic           clk,
  input logic           rst,
  snpu_step_if.sink     step,
  snpu_result_if.source result,
  snpu_cfg_if.sink      cfg
);
  import snpu_pkg::*;

  // The index is 10 bits wide, so at most 1024 entries can ever be reached.
  localparam int IDX_SPAN   = 1 << IDX_W;
  localparam int MEM_DEPTH  = (NEURONS < IDX_SPAN) ? NEURONS : IDX_SPAN;
  localparam int ADDR_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  // Reciprocal for the index fold. With a 2*IDX_W shift the rounding error
  // stays below 1/NEURONS, so the quotient is exact without correction.
  localparam int RECIP_SH   = 2 * IDX_W;
  localparam int RECIP_W    = RECIP_SH + 1;
  localparam int RECIP      = ((1 << RECIP_SH) + NEURONS - 1) / NEURONS;
  // Pipeline positions after the memory read, up to the write-back register.
  localparam int PIPE_LEN   = 17;
  localparam int HS_LAT     = 5;
  localparam int OUT_DEPTH  = 32;
  localparam int OUT_PTR_W  = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W  = OUT_PTR_W + 1;
  localparam int BV_W       = RATE_W + 1 + DATA_W;
  localparam int DU_W       = STEP_W + 1 + 33;
  localparam int INIT_W     = RATE_W + 1 + POT_W;

  // --------------------------------------------------------------------------
  // Configuration registers. The port never stalls; indexes beyond the list
  // are dropped.
  // --------------------------------------------------------------------------
  logic [RATE_W-1:0]       recovery_rate;
  logic [RATE_W-1:0]       recovery_sensitivity;
  logic signed [POT_W-1:0] reset_potential;
  logic signed [POT_W-1:0] recovery_jump;
  logic signed [POT_W-1:0] peak_potential;
  logic signed [POT_W-1:0] initial_potential;
  logic [STEP_W-1:0]       step_ms;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      recovery_rate        <= RST_RECOVERY_RATE;
      recovery_sensitivity <= RST_RECOVERY_SENSITIVITY;
      reset_potential      <= RST_RESET_POTENTIAL;
      recovery_jump        <= RST_RECOVERY_JUMP;
      peak_potential       <= RST_PEAK_POTENTIAL;
      initial_potential    <= RST_INITIAL_POTENTIAL;
      step_ms              <= RST_STEP_MS;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        CFG_RECOVERY_RATE:        recovery_rate        <= cfg.data[RATE_W-1:0];
        CFG_RECOVERY_SENSITIVITY: recovery_sensitivity <= cfg.data[RATE_W-1:0];
        CFG_RESET_POTENTIAL:      reset_potential      <= cfg.data[POT_W-1:0];
        CFG_RECOVERY_JUMP:        recovery_jump        <= cfg.data[POT_W-1:0];
        CFG_PEAK_POTENTIAL:       peak_potential       <= cfg.data[POT_W-1:0];
        CFG_INITIAL_POTENTIAL:    initial_potential    <= cfg.data[POT_W-1:0];
        CFG_STEP_MS:              step_ms              <= cfg.data[STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The recovery loaded on reinitialise depends only on registers, so it is
  // kept ready in a register of its own. The user must change registers only
  // while the block is idle; the block itself does not enforce this.
  logic signed [INIT_W-1:0] init_prod;
  fix_t                     init_u;

  assign init_prod = $signed({1'b0, recovery_sensitivity}) * initial_potential;

  always_ff @(posedge clk) begin
    init_u <= DATA_W'(init_prod >>> 16);
  end

  // --------------------------------------------------------------------------
  // Front end. F1 registers the accepted item and starts the index fold, F2
  // holds the folded memory slot and issues the item when the slot is not in
  // flight and the result queue has room reserved for it.
  // --------------------------------------------------------------------------
  logic                 f1_valid;
  logic                 f1_action;
  logic [IDX_W-1:0]     f1_idx;
  fix_t                 f1_cur;
  logic [IDX_W-1:0]     f1_slot_calc;
  logic                 f2_valid;
  logic                 f2_action;
  logic [IDX_W-1:0]     f2_idx;
  logic [IDX_W-1:0]     f2_slot;
  fix_t                 f2_cur;
  logic                 f1_load;
  logic                 f2_load;
  logic                 f2_go;
  logic                 hazard;
  logic [OUT_CNT_W-1:0] outstanding;

  item_t                sb [1:PIPE_LEN];
  logic [PIPE_LEN:1]    sb_valid;

  assign f2_go   = f2_valid && !hazard && (outstanding < OUT_CNT_W'(OUT_DEPTH));
  assign f2_load = f1_valid && (!f2_valid || f2_go);
  assign f1_load = step.valid && step.ready;
  assign step.ready = !f1_valid || f2_load;

  generate
    if (NEURONS < IDX_SPAN) begin : g_fold
      logic [IDX_W+RECIP_W-1:0] fold_prod;
      logic [2*IDX_W-1:0]       fold_back;
      logic [IDX_W-1:0]         f1_quot;

      assign fold_prod = (IDX_W+RECIP_W)'(step.neuron_index) * (IDX_W+RECIP_W)'(RECIP);
      assign fold_back = (2*IDX_W)'(f1_quot) * (2*IDX_W)'(NEURONS);
      assign f1_slot_calc = f1_idx - fold_back[IDX_W-1:0];

      always_ff @(posedge clk) begin
        if (f1_load) begin
          f1_quot <= fold_prod[RECIP_SH +: IDX_W];
        end
      end
    end else begin : g_direct
      assign f1_slot_calc = f1_idx;
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else begin
      if (f1_load) begin
        f1_valid <= 1'b1;
      end else if (f2_load) begin
        f1_valid <= 1'b0;
      end
      if (f2_load) begin
        f2_valid <= 1'b1;
      end else if (f2_go) begin
        f2_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (f1_load) begin
      f1_action <= step.action;
      f1_idx    <= step.neuron_index;
      f1_cur    <= step.input_current;
    end
    if (f2_load) begin
      f2_action <= f1_action;
      f2_idx    <= f1_idx;
      f2_slot   <= f1_slot_calc;
      f2_cur    <= f1_cur;
    end
  end

  // Interlock: a neuron may have only one update in flight, from its memory
  // read to its write-back. The write-back position is included because the
  // memory returns old data on a read in the same cycle as the write.
  always_comb begin
    hazard = 1'b0;
    for (int i = 1; i <= PIPE_LEN; i++) begin
      if (sb_valid[i] && (sb[i].slot == f2_slot)) begin
        hazard = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // State memory: potential and recovery side by side in one word. It is read
  // when an item issues and written when the item leaves the last position.
  // --------------------------------------------------------------------------
  logic [2*DATA_W-1:0] mem [MEM_DEPTH];
  fix_t                rd_v;
  fix_t                rd_u;
  fix_t                fin_v;
  fix_t                fin_u;
  logic                fin_spiked;

  always_ff @(posedge clk) begin
    if (f2_go) begin
      {rd_v, rd_u} <= mem[f2_slot[ADDR_W-1:0]];
    end
    if (sb_valid[PIPE_LEN]) begin
      mem[sb[PIPE_LEN].slot[ADDR_W-1:0]] <= {fin_v, fin_u};
    end
  end

  // Side line: item information and the old recovery ride along with the
  // arithmetic. The recovery joins at position 2, right after the read.
  fix_t u_dly [2:PIPE_LEN];

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_valid <= '0;
    end else begin
      sb_valid <= {sb_valid[PIPE_LEN-1:1], f2_go};
    end
  end

  always_ff @(posedge clk) begin
    sb[1] <= item_t'{action: f2_action, idx: f2_idx, slot: f2_slot, cur: f2_cur};
    for (int i = 2; i <= PIPE_LEN; i++) begin
      sb[i] <= sb[i-1];
    end
    u_dly[2] <= rd_u;
    for (int i = 3; i <= PIPE_LEN; i++) begin
      u_dly[i] <= u_dly[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // Potential: two half-steps, each five stages, with the same u and I.
  // The first takes the memory data at position 1, the second starts at 6.
  // --------------------------------------------------------------------------
  fix_t v_hs1;
  fix_t v_hs2;

  snpu_half_step u_hs1 (
    .clk     (clk),
    .step_ms (step_ms),
    .v       (rd_v),
    .u       (rd_u),
    .cur     (sb[1].cur),
    .v_half  (v_hs1)
  );

  snpu_half_step u_hs2 (
    .clk     (clk),
    .step_ms (step_ms),
    .v       (v_hs1),
    .u       (u_dly[1+HS_LAT]),
    .cur     (sb[1+HS_LAT].cur),
    .v_half  (v_hs2)
  );

  // --------------------------------------------------------------------------
  // Recovery: du = dt * a * (b*v - u), one multiplication per stage, using
  // the new potential. Positions 12 to 16 with the spike compare at 16, then
  // the write-back values at 17.
  // --------------------------------------------------------------------------
  logic signed [BV_W-1:0] bv12;
  fix_t                   v12;
  fix_t                   df13;
  fix_t                   v13;
  logic signed [BV_W-1:0] adf14;
  fix_t                   v14;
  logic signed [32:0]     adf_hi;
  logic signed [DU_W-1:0] du15;
  fix_t                   v15;
  fix_t                   un16;
  fix_t                   v16;
  logic                   spk16;

  assign adf_hi = $signed(adf14[BV_W-1:16]);

  always_ff @(posedge clk) begin
    bv12 <= $signed({1'b0, recovery_sensitivity}) * v_hs2;
    v12  <= v_hs2;

    df13 <= sat32(64'(bv12 >>> 16) - 64'(u_dly[12]));
    v13  <= v12;

    adf14 <= $signed({1'b0, recovery_rate}) * df13;
    v14   <= v13;

    du15 <= $signed({1'b0, step_ms}) * adf_hi;
    v15  <= v14;

    un16  <= sat32(64'(u_dly[15]) + 64'(du15 >>> 16));
    v16   <= v15;
    spk16 <= (v15 >= DATA_W'(peak_potential));

    // Write-back values. A reinitialise ignores the arithmetic entirely and
    // never reports a spike. A spike resets v to c and kicks u by d.
    fin_spiked <= !sb[16].action && spk16;
    if (sb[16].action) begin
      fin_v <= DATA_W'(initial_potential);
      fin_u <= init_u;
    end else if (spk16) begin
      fin_v <= DATA_W'(reset_potential);
      fin_u <= sat32(64'(un16) + 64'(recovery_jump));
    end else begin
      fin_v <= v16;
      fin_u <= un16;
    end
  end

  // --------------------------------------------------------------------------
  // Result queue. The pipeline itself never stalls: an item issues only when
  // a queue entry is reserved for it, so backpressure on the result side
  // only holds items in the front end.
  // --------------------------------------------------------------------------
  result_t              out_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;
  logic [OUT_CNT_W-1:0] fifo_count;
  logic                 push;
  logic                 pop;

  assign push = sb_valid[PIPE_LEN];
  assign pop  = result.valid && result.ready;

  assign result.valid         = (fifo_count != '0);
  assign result.out_index     = out_q[rd_ptr].idx;
  assign result.spiked        = out_q[rd_ptr].spiked;
  assign result.new_potential = out_q[rd_ptr].v;
  assign result.new_recovery  = out_q[rd_ptr].u;

  always_ff @(posedge clk) begin
    if (push) begin
      out_q[wr_ptr] <= result_t'{idx: sb[PIPE_LEN].idx, spiked: fin_spiked,
                                 v: fin_v, u: fin_u};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr      <= '0;
      rd_ptr      <= '0;
      fifo_count  <= '0;
      outstanding <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fifo_count <= fifo_count + 1'b1;
      end else if (pop && !push) begin
        fifo_count <= fifo_count - 1'b1;
      end
      if (f2_go && !pop) begin
        outstanding <= outstanding + 1'b1;
      end else if (pop && !f2_go) begin
        outstanding <= outstanding - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    outstanding <= OUT_CNT_W'(OUT_DEPTH))
    else $error("more items issued than the result queue can hold");

  a_queue_subset: assert property (@(posedge clk) disable iff (rst)
    fifo_count <= outstanding)
    else $error("result queue holds items that were never issued");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push |-> (fifo_count != OUT_CNT_W'(OUT_DEPTH)))
    else $error("write into a full result queue");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    sb_valid[PIPE_LEN] && sb_valid[1] |-> (sb[PIPE_LEN].slot != sb[1].slot))
    else $error("two updates of the same neuron in flight");
`endif

endmodule

### hdl/snpu_half_step.sv
// ----------------------------------------------------------------------------
// snpu_half_step: one Euler half-step of the membrane potential
// Five-stage pipeline computing v + dt/2 * (0.04v^2 + 5v + 140 - u + I).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module snpu_half_step (
  input  logic                               clk,
  input  logic [snpu_pkg::STEP_W-1:0]        step_ms,
  input  logic signed [snpu_pkg::DATA_W-1:0] v,
  input  logic signed [snpu_pkg::DATA_W-1:0] u,
  input  logic signed [snpu_pkg::DATA_W-1:0] cur,
  output logic signed [snpu_pkg::DATA_W-1:0] v_half
);
  import snpu_pkg::*;

  localparam int SQ_W   = 47;
  localparam int T_W    = 59;
  localparam int PROD_W = STEP_W + 1 + DATA_W;

  logic signed [63:0]       sq_full;
  logic signed [LIN_W-1:0]  lin_s1;
  fix_t                     v_s1;
  logic [T_W-1:0]           t_s2;
  logic signed [LIN_W-1:0]  lin_s2;
  fix_t                     v_s2;
  fix_t                     dv_s3;
  fix_t                     v_s3;
  logic signed [PROD_W-1:0] p_s4;
  fix_t                     v_s4;
  logic signed [LIN_W-1:0]  lin_next;

  // Linear part of the derivative: 5v + 140 - u + I.
  assign lin_next = (LIN_W'(v) <<< 2) + LIN_W'(v) + Q_140 - LIN_W'(u) + LIN_W'(cur);

  always_ff @(posedge clk) begin
    sq_full <= v * v;
    lin_s1  <= lin_next;
    v_s1    <= v;

    // The square is never negative, so its top bit can be dropped.
    t_s2   <= T_W'(sq_full[SQ_W+15:16]) * T_W'(K_QUAD);
    lin_s2 <= lin_s1;
    v_s2   <= v_s1;

    dv_s3 <= sat32(64'($signed({1'b0, t_s2[T_W-1:16]})) + 64'(lin_s2));
    v_s3  <= v_s2;

    p_s4 <= $signed({1'b0, step_ms}) * dv_s3;
    v_s4 <= v_s3;

    v_half <= sat32(64'(v_s4) + 64'(p_s4 >>> 17));
  end

endmodule

### tb/sv/spiking_neuron_population_update_checker.sv
// ----------------------------------------------------------------------------
// spiking_neuron_population_update_checker: prediction and comparison
// Watches the step, result and configuration channels, keeps its own copy of
// the neuron state and the parameters, and compares every result with the
// oldest expected update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spiking_neuron_population_update_checker #(
  parameter int NEURONS = 1024
) (
  input  logic   clk,
  input  logic   rst,
  snpu_step_if   step,
  snpu_result_if result,
  snpu_cfg_if    cfg,
  output int     mismatches,
  output int     outstanding
);
  import snpu_pkg::*;

  localparam longint QUAD_COEF  = 2621;
  localparam longint REST_DRIVE = 140 * 65536;
  localparam int     PRINT_CAP  = 40;

  // Parameter copy, in the same formats as the block's registers.
  logic [RATE_W-1:0]       rate_a;
  logic [RATE_W-1:0]       sens_b;
  logic signed [POT_W-1:0] spike_reset_c;
  logic signed [POT_W-1:0] jump_d;
  logic signed [POT_W-1:0] peak_v;
  logic signed [POT_W-1:0] init_v;
  logic [STEP_W-1:0]       dt_ms;

  fix_t    potential_mem [NEURONS];
  fix_t    recovery_mem  [NEURONS];
  result_t pending_updates [$];
  result_t oldest;
  int      mismatch_count = 0;
  int      waiting = 0;

  assign mismatches  = mismatch_count;
  assign outstanding = waiting;

  function automatic longint clamp32(input longint x);
    if (x > FIX_MAX) begin
      return FIX_MAX;
    end
    if (x < FIX_MIN) begin
      return FIX_MIN;
    end
    return x;
  endfunction

  // One half-step slope of the membrane equation.
  function automatic longint membrane_slope(input longint v, input longint u,
                                            input longint i);
    longint sq;
    sq = (v * v) >>> 16;
    return clamp32(((sq * QUAD_COEF) >>> 16) + 5 * v + REST_DRIVE - u + i);
  endfunction

  // Works out the update of one neuron and writes it back to the copy.
  function automatic result_t neuron_update(input logic reinit,
                                            input logic [IDX_W-1:0] idx,
                                            input fix_t cur);
    longint  v;
    longint  u;
    longint  i;
    longint  df;
    longint  a;
    longint  b;
    longint  dt;
    int      slot;
    result_t r;
    a        = longint'(rate_a);
    b        = longint'(sens_b);
    dt       = longint'(dt_ms);
    i        = longint'(cur);
    slot     = int'(idx) % NEURONS;
    r.idx    = idx;
    r.spiked = 1'b0;
    if (reinit) begin
      v = longint'(init_v);
      u = (b * v) >>> 16;
    end else begin
      v  = longint'(potential_mem[slot]);
      u  = longint'(recovery_mem[slot]);
      v  = clamp32(v + ((dt * membrane_slope(v, u, i)) >>> 17));
      v  = clamp32(v + ((dt * membrane_slope(v, u, i)) >>> 17));
      df = clamp32(((b * v) >>> 16) - u);
      u  = clamp32(u + ((dt * ((a * df) >>> 16)) >>> 16));
      if (v >= longint'(peak_v)) begin
        r.spiked = 1'b1;
        v        = longint'(spike_reset_c);
        u        = clamp32(u + longint'(jump_d));
      end
    end
    potential_mem[slot] = fix_t'(v);
    recovery_mem[slot]  = fix_t'(u);
    r.v = fix_t'(v);
    r.u = fix_t'(u);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) begin
      $display("[%0t] mismatch: %s", $realtime, what);
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rate_a        <= RST_RECOVERY_RATE;
      sens_b        <= RST_RECOVERY_SENSITIVITY;
      spike_reset_c <= RST_RESET_POTENTIAL;
      jump_d        <= RST_RECOVERY_JUMP;
      peak_v        <= RST_PEAK_POTENTIAL;
      init_v        <= RST_INITIAL_POTENTIAL;
      dt_ms         <= RST_STEP_MS;
      pending_updates.delete();
      waiting       <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_RECOVERY_RATE:        rate_a        <= cfg.data[RATE_W-1:0];
          CFG_RECOVERY_SENSITIVITY: sens_b        <= cfg.data[RATE_W-1:0];
          CFG_RESET_POTENTIAL:      spike_reset_c <= cfg.data[POT_W-1:0];
          CFG_RECOVERY_JUMP:        jump_d        <= cfg.data[POT_W-1:0];
          CFG_PEAK_POTENTIAL:       peak_v        <= cfg.data[POT_W-1:0];
          CFG_INITIAL_POTENTIAL:    init_v        <= cfg.data[POT_W-1:0];
          CFG_STEP_MS:              dt_ms         <= cfg.data[STEP_W-1:0];
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        if (pending_updates.size() == 0) begin
          report_mismatch($sformatf("result for neuron %0d with nothing expected",
                                    result.out_index));
        end else begin
          oldest = pending_updates.pop_front();
          if (result.out_index !== oldest.idx) begin
            report_mismatch($sformatf("index expected %0d got %0d",
                                      oldest.idx, result.out_index));
          end
          if (result.spiked !== oldest.spiked) begin
            report_mismatch($sformatf("neuron %0d spike flag expected %0b got %0b",
                                      oldest.idx, oldest.spiked, result.spiked));
          end
          if (result.new_potential !== oldest.v) begin
            report_mismatch($sformatf("neuron %0d potential expected %0d got %0d",
                                      oldest.idx, oldest.v, result.new_potential));
          end
          if (result.new_recovery !== oldest.u) begin
            report_mismatch($sformatf("neuron %0d recovery expected %0d got %0d",
                                      oldest.idx, oldest.u, result.new_recovery));
          end
        end
      end
      if (step.valid && step.ready) begin
        pending_updates.push_back(neuron_update(step.action, step.neuron_index,
                                                step.input_current));
      end
      waiting <= pending_updates.size();
    end
  end

endmodule

### tb/sv/spiking_neuron_population_update_test.sv
// ----------------------------------------------------------------------------
// spiking_neuron_population_update_test: top of the neuron update testbench
// Drives step items and register writes into the block, stalls the result
// side at random, and gives the verdict from the checker's mismatch count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spiking_neuron_population_update_test;
  import snpu_pkg::*;

  localparam int NEURONS       = 1024;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 800;
  localparam int HOT_COUNT     = 12;

  // Step actions.
  localparam logic ACT_ADVANCE = 1'b0;
  localparam logic ACT_REINIT  = 1'b1;

  // The one index on the configuration port that names no register.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_SLOT = 3'd7;

  localparam fix_t CUR_MAX = 32'sh7FFF_FFFF;
  localparam fix_t CUR_MIN = 32'sh8000_0000;

  logic clk = 1'b0;
  logic rst;
  logic sink_ready = 1'b0;

  snpu_step_if   step ();
  snpu_result_if result ();
  snpu_cfg_if    cfg ();

  int mismatches;
  int outstanding;

  // Control shared between the stimulus and the result-side process. Both are
  // written with nonblocking assignments so the receiver samples them cleanly.
  bit idling_on     = 1'b1;
  int hold_requests = 0;
  int holds_served  = 0;
  int hold_left     = 0;
  int stall_left    = 0;
  int cycles        = 0;

  // A neuron may only be advanced after it has been reinitialised once, since
  // its stored state is undefined before that.
  bit               primed [NEURONS];
  logic [IDX_W-1:0] hot [HOT_COUNT];

  int reinit_count   = 0;
  int advance_count  = 0;
  int spike_count    = 0;
  int settings_count = 1;

  spiking_neuron_population_update #(
    .NEURONS(NEURONS)
  ) u_top (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .result(result),
    .cfg   (cfg)
  );

  spiking_neuron_population_update_checker #(
    .NEURONS(NEURONS)
  ) u_check (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .result     (result),
    .cfg        (cfg),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always #10 clk = ~clk;

  assign result.ready = sink_ready;

  // Result side. A pending long hold takes priority: the receiver then refuses
  // results throughout the hold while the sender keeps pushing, so the pipeline
  // fills and the block has to back-pressure its step input. Otherwise short
  // random stalls come and go while idling is enabled.
  always @(posedge clk) begin
    if (rst) begin
      sink_ready <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
    end else if (hold_left > 0) begin
      sink_ready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      holds_served <= hold_requests;
      hold_left    <= HOLD_CYCLES - 1;
      sink_ready   <= 1'b0;
    end else if (stall_left > 0) begin
      sink_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      sink_ready <= 1'b0;
      stall_left <= $urandom_range(0, 13);
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // Spikes seen on the result side, for the summary only.
  always @(posedge clk) begin
    if (!rst && result.valid && result.ready && result.spiked) begin
      spike_count <= spike_count + 1;
    end
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run timed out after %0d cycles with %0d results outstanding",
               cycles, outstanding);
      $display("FAILURE");
      $finish;
    end
  end

  // Offers one step item and returns at the edge where it is accepted. When
  // no gap is taken, valid simply stays high and the fields change, so the
  // next item follows back to back.
  task automatic send_step(input logic act, input logic [IDX_W-1:0] idx,
                           input fix_t cur);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      step.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    step.valid         <= 1'b1;
    step.action        <= act;
    step.neuron_index  <= idx;
    step.input_current <= cur;
    @(posedge clk);
    while (!step.ready) @(posedge clk);
    if (act == ACT_REINIT) begin
      primed[idx] = 1'b1;
      reinit_count++;
    end else begin
      advance_count++;
    end
  endtask

  // Advances a neuron, or brings it up first if it was never reinitialised.
  // The current on a reinitialise item is ignored, so it is left random.
  task automatic advance_or_prime(input logic [IDX_W-1:0] idx, input fix_t cur);
    if (primed[idx]) begin
      send_step(ACT_ADVANCE, idx, cur);
    end else begin
      send_step(ACT_REINIT, idx, fix_t'($urandom));
    end
  endtask

  // A current in the range that keeps a neuron in its normal firing regime,
  // from -10 to +40 in Q15.16.
  function automatic fix_t typical_current();
    return fix_t'(int'($urandom_range(0, 50 << 16)) - (10 << 16));
  endfunction

  // Millivolts to a Q7.16 register word.
  function automatic logic [CFG_DATA_W-1:0] q16(input int mv);
    return CFG_DATA_W'(mv * 65536);
  endfunction

  // One register write. Like the step side, valid stays high between writes
  // and is lowered by the caller after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      cfg.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    cfg.valid <= 1'b1;
    cfg.index <= index;
    cfg.data  <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
  endtask

  // Writes all seven parameters; only called while the block is drained.
  task automatic load_settings(input logic [CFG_DATA_W-1:0] a,
                               input logic [CFG_DATA_W-1:0] b,
                               input logic [CFG_DATA_W-1:0] c,
                               input logic [CFG_DATA_W-1:0] d,
                               input logic [CFG_DATA_W-1:0] peak,
                               input logic [CFG_DATA_W-1:0] vinit,
                               input logic [CFG_DATA_W-1:0] dt);
    write_reg(CFG_RECOVERY_RATE, a);
    write_reg(CFG_RECOVERY_SENSITIVITY, b);
    write_reg(CFG_RESET_POTENTIAL, c);
    write_reg(CFG_RECOVERY_JUMP, d);
    write_reg(CFG_PEAK_POTENTIAL, peak);
    write_reg(CFG_INITIAL_POTENTIAL, vinit);
    write_reg(CFG_STEP_MS, dt);
    cfg.valid <= 1'b0;
    settings_count++;
  endtask

  // Stops offering items and waits until every expected result is back. A
  // further settling wait follows, so the block is truly idle before any
  // register changes. The first edge lets the checker's count catch up with
  // an item accepted at the current edge.
  task automatic settle();
    step.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Directed opening: both actions, the index extremes and alternating bit
  // patterns, the current extremes that drive the state into saturation in
  // both directions, back-to-back updates of one neuron through the
  // pipeline, and a neuron driven until it fires under the reset parameters.
  task automatic directed_items();
    int n;
    send_step(ACT_REINIT, 10'd0, CUR_MAX);
    send_step(ACT_REINIT, 10'd1023, CUR_MIN);
    send_step(ACT_REINIT, 10'h2AA, 32'sh5555_5555);
    send_step(ACT_REINIT, 10'h155, 32'shAAAA_AAAA);
    send_step(ACT_ADVANCE, 10'd0, 32'sd0);
    send_step(ACT_ADVANCE, 10'd0, fix_t'(10 << 16));
    send_step(ACT_ADVANCE, 10'd0, fix_t'(10 << 16));
    send_step(ACT_ADVANCE, 10'd1023, CUR_MAX);
    send_step(ACT_ADVANCE, 10'd1023, CUR_MAX);
    send_step(ACT_ADVANCE, 10'h2AA, CUR_MIN);
    send_step(ACT_ADVANCE, 10'h2AA, CUR_MIN);
    send_step(ACT_ADVANCE, 10'h155, -32'sd1);
    send_step(ACT_ADVANCE, 10'h155, 32'sd1);
    for (n = 0; n < 8; n++) begin
      send_step(ACT_ADVANCE, 10'h155, fix_t'(40 << 16));
    end
    send_step(ACT_REINIT, 10'd1023, 32'sd0);
    send_step(ACT_ADVANCE, 10'd1023, fix_t'(5 << 16));
  endtask

  // Random part. Most items advance a small working set of neurons with
  // everyday currents, so each of them integrates over many ticks, fires and
  // recovers, and often arrives back to back with its own update still in
  // flight. The rest reinitialise, touch any neuron in the population, or
  // push extreme and fully random currents.
  task automatic random_items(input int count);
    int n;
    int roll;
    for (n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        send_step(ACT_REINIT, IDX_W'($urandom), fix_t'($urandom));
      end else if (roll < 66) begin
        advance_or_prime(hot[$urandom_range(0, HOT_COUNT - 1)], typical_current());
      end else if (roll < 82) begin
        advance_or_prime(IDX_W'($urandom), typical_current());
      end else if (roll < 94) begin
        advance_or_prime(hot[$urandom_range(0, HOT_COUNT - 1)], fix_t'($urandom));
      end else begin
        advance_or_prime(hot[$urandom_range(0, HOT_COUNT - 1)],
                         ($urandom_range(0, 1) == 1) ? CUR_MAX : CUR_MIN);
      end
    end
  endtask

  initial begin
    int k;
    rst                <= 1'b1;
    step.valid         <= 1'b0;
    step.action        <= ACT_ADVANCE;
    step.neuron_index  <= '0;
    step.input_current <= '0;
    cfg.valid          <= 1'b0;
    cfg.index          <= CFG_RECOVERY_RATE;
    cfg.data           <= '0;
    for (k = 0; k < HOT_COUNT; k++) begin
      hot[k] = IDX_W'($urandom);
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset parameters: directed opening, then random traffic with one long
    // result-side hold in the middle of it.
    directed_items();
    random_items(40);
    hold_requests <= hold_requests + 1;
    random_items(40);
    settle();

    // Every register at its top value: long steps drive the state into
    // positive saturation and the jump after a spike saturates as well.
    load_settings(24'h00FFFF, 24'h00FFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF,
                  24'h7FFFFF, 24'h0FFFFF);
    random_items(100);
    settle();

    // Every register at its bottom value: a zero step freezes the potential,
    // and the lowest possible peak makes every advance a spike.
    load_settings(24'h000000, 24'h000000, 24'h800000, 24'h800000, 24'h800000,
                  24'h800000, 24'h000000);
    random_items(100);
    settle();

    // Raw random register words, including the bits above the rate and step
    // registers' widths that the block has to drop.
    load_settings(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                  CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                  CFG_DATA_W'($urandom), CFG_DATA_W'($urandom),
                  CFG_DATA_W'($urandom));
    random_items(90);
    settle();

    // Two plausible neuron types with randomized parameters.
    repeat (2) begin
      load_settings(CFG_DATA_W'($urandom_range(600, 6600)),
                    CFG_DATA_W'($urandom_range(6000, 19000)),
                    q16(-int'($urandom_range(50, 70))),
                    q16(int'($urandom_range(0, 10))),
                    q16(int'($urandom_range(20, 40))),
                    q16(-int'($urandom_range(55, 75))),
                    CFG_DATA_W'($urandom_range(16384, 98304)));
      random_items(90);
      settle();
    end

    // Back to the reset parameters by explicit writes, plus one write to the
    // unused index. The final stretch runs with no idling on either side.
    load_settings(CFG_DATA_W'(RST_RECOVERY_RATE), CFG_DATA_W'(RST_RECOVERY_SENSITIVITY),
                  RST_RESET_POTENTIAL, RST_RECOVERY_JUMP, RST_PEAK_POTENTIAL,
                  RST_INITIAL_POTENTIAL, CFG_DATA_W'(RST_STEP_MS));
    write_reg(CFG_UNUSED_SLOT, CFG_DATA_W'($urandom));
    cfg.valid <= 1'b0;
    random_items(30);
    idling_on <= 1'b0;
    random_items(70);
    settle();

    $display("Sent %0d advance and %0d reinitialise items under %0d parameter settings",
             advance_count, reinit_count, settings_count);
    $display("Saw %0d spikes; %0d mismatches", spike_count, mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
